>>> hdl/hrlm_pkg.sv
// shared constants and helpers for the haversine route length block
// fixed-point formats: angles Q2.30, h in Q60, distances in 2^-16 km
package hrlm_pkg;

    localparam int AW = 34;   // cordic x/y and multiplier operand width
    localparam int ZW = 36;   // angle width

    localparam logic signed [AW-1:0] KINV_Q30    = 34'sd652032874;
    localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [AW-1:0] RAD_MUL     = 34'sd503056906;
    localparam logic signed [AW-1:0] DIAM_KM     = 34'sd12742;
    localparam logic [60:0]          ONE_Q60     = 61'h1000_0000_0000_0000;
    localparam logic [47:0]          MASK48      = 48'hFFFF_FFFF_FFFF;

    typedef enum logic {
        t_rotate = 1'b0,
        t_vector = 1'b1
    } t_cordic_mode;

    // atan(2^-i) in Q30: table head, then 2^(30-i), then zero
    function automatic logic [31:0] atan_step(input logic [5:0] i);
        logic [31:0] v;
        unique case (i)
            6'd0: v = 32'd843314856;
            6'd1: v = 32'd497837829;
            6'd2: v = 32'd263043836;
            6'd3: v = 32'd133525158;
            6'd4: v = 32'd67021686;
            6'd5: v = 32'd33543515;
            6'd6: v = 32'd16775850;
            6'd7: v = 32'd8388437;
            6'd8: v = 32'd4194282;
            6'd9: v = 32'd2097149;
            default: v = (i <= 6'd30) ? (32'd1 << (6'd30 - i)) : 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/hrlm_cordic.sv
// iterative cordic unit: rotation (sin/cos with quadrant fold) and vectoring
// one micro-rotation per cycle; depends on hrlm_pkg
module hrlm_cordic import hrlm_pkg::*; #(
    parameter int STEPS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_cordic_mode         i_mode,
    input  logic signed [AW-1:0] i_x,
    input  logic signed [AW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic                 o_done,
    output logic signed [AW-1:0] o_x,
    output logic signed [AW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    localparam int CW = $clog2(STEPS + 1);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    t_cordic_mode       r_mode;
    logic               r_neg_cos;
    logic signed [AW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [ZW-1:0] f0, f1, f2, f3, fa;
    logic                 fneg;
    logic signed [AW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    logic                 dir_pos;

    // fold angle into [-pi/2, pi/2]
    always_comb begin
        f0 = (i_z > PI_Q30) ? i_z - TWO_PI_Q30 : i_z;
        f1 = (f0 > PI_Q30) ? f0 - TWO_PI_Q30 : f0;
        f2 = (f1 < -PI_Q30) ? f1 + TWO_PI_Q30 : f1;
        f3 = (f2 < -PI_Q30) ? f2 + TWO_PI_Q30 : f2;
        fneg = 1'b0;
        fa   = f3;
        if (f3 > HALF_PI_Q30) begin
            fa   = PI_Q30 - f3;
            fneg = 1'b1;
        end else if (f3 < -HALF_PI_Q30) begin
            fa   = -PI_Q30 - f3;
            fneg = 1'b1;
        end
    end

    // one micro-rotation
    always_comb begin
        dx = r_y >>> r_cnt;
        dy = r_x >>> r_cnt;
        at = ZW'(signed'({1'b0, atan_step(6'(r_cnt))}));
        dir_pos = (r_mode == t_rotate) ? (r_z >= 0) : (r_y <= 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_mode <= i_mode;
                if (i_mode == t_rotate) begin
                    r_x <= KINV_Q30;
                    r_y <= '0;
                    r_z <= fa;
                    r_neg_cos <= fneg;
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                    r_neg_cos <= 1'b0;
                end
            end else if (r_busy) begin
                // rotate: positive direction drives z down; vector: y>0 drives y down
                if (r_mode == t_rotate) begin
                    if (dir_pos) begin
                        r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + at;
                    end
                end else begin
                    if (!dir_pos) begin
                        r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + at;
                    end else begin
                        r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - at;
                    end
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_neg_cos ? -r_x : r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

>>> hdl/hrlm_sqrt.sv
// bit-serial floor square root of a Q60 value, one result bit per cycle
// depends on hrlm_pkg
module hrlm_sqrt import hrlm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [60:0] i_n,
    output logic        o_done,
    output logic [30:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_k;
    logic [61:0] r_rem, r_root, r_bit;
    logic [61:0] trial;

    assign trial = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_rem  <= {1'b0, i_n};
                r_root <= '0;
                r_bit  <= 62'd1 << 60;
            end else if (r_busy) begin
                // compare and subtract one bit pair
                if (r_rem >= trial) begin
                    r_rem  <= r_rem - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_k   <= r_k + 1'b1;
                if (r_k == 5'd30) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[30:0];

endmodule

>>> hdl/haversine_route_length_minimum_top.sv
// top level: waypoint sequencer, shared multiplier, route sum and minimum
// depends on hrlm_pkg, hrlm_cordic, hrlm_sqrt
//
// Each waypoint takes one transfer and then holds o_stall high while a small
// sequencer computes the leg: four degree-to-radian products, four cordic
// sin/cos runs, four multiplies for h, two 31-step square roots, one cordic
// vectoring run and the final scale. How long a leg holds o_stall is set by
// the single cordic unit and the square roots, and the next transfer is taken
// only once the sequencer is back in idle; a waypoint that starts a route
// skips the leg and goes straight to its result. The result sits in an output
// register, so the next waypoint is taken while it waits for the consumer.
module haversine_route_length_minimum_top import hrlm_pkg::*; #(
    parameter int MAX_ROUTES   = 256,
    parameter int CORDIC_STEPS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [30:0] i_lat_e7,
    input  logic signed [31:0] i_lon_e7,
    input  logic               i_route_first,
    input  logic               i_route_last,
    input  logic               i_set_first,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [30:0]        o_leg_dist,
    output logic [47:0]        o_route_dist,
    output logic               o_route_done,
    output logic [7:0]         o_best_route,
    output logic [47:0]        o_best_dist,
    output logic               o_new_best
);

    localparam logic [7:0] LIMIT = (MAX_ROUTES - 1 > 255) ? 8'd255 : 8'(MAX_ROUTES - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_RAD, S_RADW, S_SC, S_SCW, S_M1, S_M2, S_M3, S_M4, S_M5,
        S_M6, S_SQ1, S_SQ2, S_VEC, S_DM, S_DMW, S_DONE
    } t_state;

    t_state r_state;
    logic [1:0] r_k;

    // latched waypoint
    logic signed [31:0] r_lat, r_lon;
    logic r_rf, r_rl, r_sf;

    // architectural state
    logic signed [31:0] r_prev_lat, r_prev_lon;
    logic [47:0] r_route_sum, r_best_sum;
    logic [7:0]  r_route_index, r_best_index;

    // datapath registers
    logic signed [AW-1:0] r_rad [4];
    logic signed [AW-1:0] r_s1, r_s2, r_c1, r_c2, r_a, r_b, r_zc;
    logic signed [67:0]   r_prod, r_p1;
    logic [60:0]          r_h;
    logic [30:0]          r_t;
    logic [30:0]          r_leg;

    // output register
    logic        r_ovalid;
    logic [30:0] r_o_leg;
    logic [47:0] r_o_route, r_o_best;
    logic        r_o_done, r_o_new;
    logic [7:0]  r_o_bidx;

    // shared units
    logic                 c_start, c_done;
    t_cordic_mode         c_mode;
    logic signed [AW-1:0] c_x, c_y, c_ox, c_oy;
    logic signed [ZW-1:0] c_z, c_oz;
    logic                 q_start, q_done;
    logic [60:0]          q_n;
    logic [30:0]          q_root;

    hrlm_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(c_start), .i_mode(c_mode),
        .i_x(c_x), .i_y(c_y), .i_z(c_z),
        .o_done(c_done), .o_x(c_ox), .o_y(c_oy), .o_z(c_oz)
    );

    hrlm_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(q_start), .i_n(q_n),
        .o_done(q_done), .o_root(q_root)
    );

    // degree value for the current radian conversion and its magnitude
    logic signed [31:0] deg;
    logic [31:0]        deg_mag;
    logic signed [AW-1:0] mul_a, mul_b;
    logic signed [67:0]   rad_rnd;
    logic signed [AW-1:0] rad_val;
    logic signed [AW:0]   dlat_w, dlon_w;
    logic signed [68:0]   h_sum;
    logic [60:0]          h_clamp;
    logic signed [67:0]   d_rnd;

    always_comb begin
        unique case (r_k)
            2'd0: deg = r_prev_lat;
            2'd1: deg = r_lat;
            2'd2: deg = r_prev_lon;
            default: deg = r_lon;
        endcase
        deg_mag = deg[31] ? 32'(-deg) : 32'(deg);
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_RAD: begin mul_a = AW'(signed'({1'b0, deg_mag})); mul_b = RAD_MUL; end
            S_M1:  begin mul_a = r_s1; mul_b = r_s1; end
            S_M2:  begin mul_a = r_c1; mul_b = r_c2; end
            S_M3:  begin mul_a = r_s2; mul_b = r_s2; end
            S_M5:  begin mul_a = r_a;  mul_b = r_b;  end
            S_DM:  begin mul_a = r_zc; mul_b = DIAM_KM; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // radian rounding, angle differences, h sum, distance rounding
    always_comb begin
        rad_rnd = (r_prod + 68'sd134217728) >>> 28;
        rad_val = deg[31] ? -AW'(rad_rnd) : AW'(rad_rnd);
        dlat_w  = (AW+1)'(r_rad[1]) - (AW+1)'(r_rad[0]);
        dlon_w  = (AW+1)'(r_rad[3]) - (AW+1)'(r_rad[2]);
        h_sum   = 69'(r_p1) + 69'(r_prod);
        // clamp h into [0, 1]
        if (h_sum < 0) begin
            h_clamp = '0;
        end else if (h_sum > 69'(ONE_Q60)) begin
            h_clamp = ONE_Q60;
        end else begin
            h_clamp = h_sum[60:0];
        end
        d_rnd   = r_prod + 68'sd8192;
    end

    // cordic and sqrt launch
    always_comb begin
        c_start = 1'b0;
        c_mode  = t_rotate;
        c_x     = '0;
        c_y     = '0;
        c_z     = '0;
        q_start = 1'b0;
        q_n     = r_h;
        unique case (r_state)
            S_SC: begin
                c_start = 1'b1;
                unique case (r_k)
                    2'd0: c_z = ZW'(dlat_w >>> 1);
                    2'd1: c_z = ZW'(dlon_w >>> 1);
                    2'd2: c_z = ZW'(r_rad[0]);
                    default: c_z = ZW'(r_rad[1]);
                endcase
            end
            S_M6: begin
                q_start = 1'b1;
                q_n     = h_clamp;
            end
            S_SQ1: begin
                if (q_done) begin
                    q_start = 1'b1;
                    q_n     = ONE_Q60 - r_h;
                end
            end
            S_SQ2: begin
                if (q_done) begin
                    c_start = 1'b1;
                    c_mode  = t_vector;
                    c_x     = AW'(signed'({1'b0, q_root}));
                    c_y     = AW'(signed'({1'b0, r_t}));
                end
            end
            default: begin
                c_start = 1'b0;
            end
        endcase
    end

    // route bookkeeping for the finishing waypoint
    logic        f_rf;
    logic [47:0] f_bs, f_sum;
    logic [7:0]  f_bi, f_ri;
    logic [48:0] f_add;
    logic        f_better;
    logic        out_free;

    always_comb begin
        f_rf  = r_rf | r_sf;
        f_bs  = r_sf ? MASK48 : r_best_sum;
        f_bi  = r_sf ? 8'd0 : r_best_index;
        f_ri  = r_sf ? 8'd0 : r_route_index;
        f_add = {1'b0, r_route_sum} + 49'(r_leg);
        f_sum = f_rf ? 48'd0 : (f_add[48] ? MASK48 : f_add[47:0]);
        f_better = r_rl && (f_sum < f_bs);
        out_free = !r_ovalid || !i_stall;
    end

    // sequencer, datapath and state
    always_ff @(posedge i_clk) begin
        r_prod <= 68'(mul_a * mul_b);
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_k           <= '0;
            r_ovalid      <= 1'b0;
            r_prev_lat    <= '0;
            r_prev_lon    <= '0;
            r_route_sum   <= '0;
            r_route_index <= '0;
            r_best_sum    <= MASK48;
            r_best_index  <= '0;
        end else begin
            // output transfer frees the register unless a new result lands
            if (r_ovalid && !i_stall && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_lat <= 32'(i_lat_e7);
                        r_lon <= i_lon_e7;
                        r_rf  <= i_route_first;
                        r_rl  <= i_route_last;
                        r_sf  <= i_set_first;
                        r_k   <= '0;
                        r_leg <= '0;
                        r_state <= (i_route_first || i_set_first) ? S_DONE : S_RAD;
                    end
                end
                S_RAD: begin
                    r_state <= S_RADW;
                end
                S_RADW: begin
                    r_rad[r_k] <= rad_val;
                    r_k        <= r_k + 1'b1;
                    r_state    <= (r_k == 2'd3) ? S_SC : S_RAD;
                end
                S_SC: begin
                    r_state <= S_SCW;
                end
                S_SCW: begin
                    if (c_done) begin
                        unique case (r_k)
                            2'd0: r_s1 <= c_oy;
                            2'd1: r_s2 <= c_oy;
                            2'd2: r_c1 <= c_ox;
                            default: r_c2 <= c_ox;
                        endcase
                        r_k     <= r_k + 1'b1;
                        r_state <= (r_k == 2'd3) ? S_M1 : S_SC;
                    end
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_p1    <= r_prod;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_a     <= AW'(r_prod >>> 30);
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_b     <= AW'(r_prod >>> 30);
                    r_state <= S_M5;
                end
                S_M5: r_state <= S_M6;
                S_M6: begin
                    // first square root starts here on the clamped h
                    r_h     <= h_clamp;
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    if (q_done) begin
                        r_t     <= q_root;
                        r_state <= S_SQ2;
                    end
                end
                S_SQ2: begin
                    if (q_done) begin
                        r_state <= S_VEC;
                    end
                end
                S_VEC: begin
                    if (c_done) begin
                        r_zc    <= (c_oz < 0) ? '0 : AW'(c_oz);
                        r_state <= S_DM;
                    end
                end
                S_DM: r_state <= S_DMW;
                S_DMW: r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_o_leg   <= f_rf ? 31'd0 : r_leg;
                        r_o_route <= f_sum;
                        r_o_done  <= r_rl;
                        r_o_bidx  <= f_better ? f_ri : f_bi;
                        r_o_best  <= f_better ? f_sum : f_bs;
                        r_o_new   <= f_better;
                        r_prev_lat   <= r_lat;
                        r_prev_lon   <= r_lon;
                        r_route_sum  <= r_rl ? 48'd0 : f_sum;
                        r_best_sum   <= f_better ? f_sum : f_bs;
                        r_best_index <= f_better ? f_ri : f_bi;
                        r_route_index <= (r_rl && f_ri < LIMIT) ? f_ri + 8'd1 : f_ri;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // distance scale is taken from the registered product in S_DMW
            if (r_state == S_DMW) begin
                r_leg <= 31'(d_rnd >>> 14);
            end
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_leg_dist   = r_o_leg;
    assign o_route_dist = r_o_route;
    assign o_route_done = r_o_done;
    assign o_best_route = r_o_bidx;
    assign o_best_dist  = r_o_best;
    assign o_new_best   = r_o_new;

    // a new minimum only comes from a closing route
    a_new_best_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_new_best |-> o_route_done)
        else $error("new minimum without route close");

    // a new minimum carries the route's own length
    a_new_best_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_new_best |-> o_best_dist == o_route_dist)
        else $error("new minimum length differs from route length");

    // a transfer in starts work, so the input stalls next cycle
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after transfer");

    // the shared cordic and sqrt never finish in the same cycle
    a_units_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(c_done && q_done))
        else $error("cordic and sqrt finished together");

endmodule

>>> tb/haversine_route_length_minimum_top_tb.sv
// testbench for haversine_route_length_minimum_top: waypoint routes against a bit-true predictor
// depends on hrlm_pkg and the top level; self-contained, no files read
`timescale 1ns / 1ps

module haversine_route_length_minimum_top_tb;
    import hrlm_pkg::*;

    localparam int MAX_ROUTES   = 256;
    localparam int CORDIC_STEPS = 32;
    localparam int IDLE_LIMIT   = 20000;

    typedef struct {
        logic [30:0] leg;
        logic [47:0] route;
        logic        done;
        logic [7:0]  best_idx;
        logic [47:0] best_len;
        logic        better;
    } t_leg_summary;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [30:0] i_lat_e7 = '0;
    logic signed [31:0] i_lon_e7 = '0;
    logic               i_route_first = 1'b0;
    logic               i_route_last = 1'b0;
    logic               i_set_first = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [30:0]        o_leg_dist;
    logic [47:0]        o_route_dist;
    logic               o_route_done;
    logic [7:0]         o_best_route;
    logic [47:0]        o_best_dist;
    logic               o_new_best;

    haversine_route_length_minimum_top #(
        .MAX_ROUTES(MAX_ROUTES),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    longint          prv_lat, prv_lon;
    longint unsigned run_sum, run_idx, min_sum, min_idx;
    t_leg_summary    pending_legs[$];

    int  errors = 0;
    int  sent = 0;
    int  checked = 0;
    int  closed_routes = 0;
    int  idle_cycles = 0;
    bit  stall_on = 1'b0;
    int  hold_req = 0;
    int  hold_cnt = 0;
    int  gap_on = 1;

    function automatic longint atan_q30(int i);
        longint head[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                             33543515, 16775850, 8388437, 4194282, 2097149};
        if (i < 10) return head[i];
        if (i <= 30) return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic longint deg_to_rad(longint v);
        longint unsigned m;
        longint r;
        m = (v < 0) ? longint'(-v) : v;
        r = longint'((m * 64'd503056906 + (64'd1 << 27)) >> 28);
        return (v < 0) ? -r : r;
    endfunction

    function automatic void rotate_sincos(input longint ang, output longint s,
                                          output longint c);
        bit     flip;
        longint x, y, z, dx, dy;
        longint pi_v, hpi_v, tpi_v;
        pi_v = PI_Q30;
        hpi_v = HALF_PI_Q30;
        tpi_v = TWO_PI_Q30;
        flip = 1'b0;
        x = KINV_Q30;
        y = 0;
        repeat (2) if (ang > pi_v) ang -= tpi_v;
        repeat (2) if (ang < -pi_v) ang += tpi_v;
        if (ang > hpi_v) begin
            ang = pi_v - ang;
            flip = 1'b1;
        end else if (ang < -hpi_v) begin
            ang = -pi_v - ang;
            flip = 1'b1;
        end
        z = ang;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_q30(i);
            end else begin
                x += dx; y -= dy; z += atan_q30(i);
            end
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    function automatic longint floor_sqrt60(longint unsigned n);
        longint unsigned rem, root, bitv;
        rem = n;
        root = 0;
        bitv = 64'd1 << 60;
        for (int k = 0; k < 31; k++) begin
            if (rem >= root + bitv) begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint great_circle_leg(longint la1, longint lo1, longint la2,
                                                longint lo2);
        longint r1, r2, dlat, dlon, s1, s2, c1, c2, dummy, h, t, c, x, y, z, dx, dy, d;
        r1 = deg_to_rad(la1);
        r2 = deg_to_rad(la2);
        dlat = (r2 - r1) >>> 1;
        dlon = (deg_to_rad(lo2) - deg_to_rad(lo1)) >>> 1;
        rotate_sincos(dlat, s1, dummy);
        rotate_sincos(dlon, s2, dummy);
        rotate_sincos(r1, dummy, c1);
        rotate_sincos(r2, dummy, c2);
        h = s1 * s1 + ((c1 * c2) >>> 30) * ((s2 * s2) >>> 30);
        if (h < 0) h = 0;
        if (h > (longint'(1) << 60)) h = longint'(1) << 60;
        t = floor_sqrt60(h);
        c = floor_sqrt60((longint'(1) << 60) - h);
        // vectoring run gives asin(t) as the angle of (c, t)
        x = c;
        y = t;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_q30(i);
            end else begin
                x -= dx; y += dy; z -= atan_q30(i);
            end
        end
        if (z < 0) z = 0;
        d = (64'sd12742 * z + 64'sd8192) >>> 14;
        return d & 64'h7FFF_FFFF;
    endfunction

    function automatic t_leg_summary predict_waypoint(longint lat, longint lon, bit rf,
                                                      bit rl, bit sf);
        t_leg_summary r;
        longint unsigned leg;
        longint unsigned cap;
        leg = 0;
        r.better = 1'b0;
        if (sf) begin
            min_sum = 48'hFFFF_FFFF_FFFF;
            min_idx = 0;
            run_idx = 0;
            rf = 1'b1;
        end
        if (rf) begin
            run_sum = 0;
        end else begin
            leg = great_circle_leg(prv_lat, prv_lon, lat, lon);
            run_sum += leg;
            if (run_sum > 64'hFFFF_FFFF_FFFF) run_sum = 64'hFFFF_FFFF_FFFF;
        end
        prv_lat = lat;
        prv_lon = lon;
        if (rl && run_sum < min_sum) begin
            min_sum = run_sum;
            min_idx = run_idx;
            r.better = 1'b1;
        end
        r.leg = leg[30:0];
        r.route = run_sum[47:0];
        r.done = rl;
        r.best_idx = min_idx[7:0];
        r.best_len = min_sum[47:0];
        if (rl) begin
            run_sum = 0;
            cap = (MAX_ROUTES - 1 > 255) ? 255 : MAX_ROUTES - 1;
            if (run_idx < cap) run_idx++;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (gap_on == 0 || p < 50) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // one waypoint transfer; valid stays high into the next call when no gap follows
    task automatic send_waypoint(input logic signed [30:0] lat, input logic signed [31:0] lon,
                                 input bit rf, input bit rl, input bit sf);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_lat_e7 <= lat;
        i_lon_e7 <= lon;
        i_route_first <= rf;
        i_route_last <= rl;
        i_set_first <= sf;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_legs.push_back(predict_waypoint(lat, lon, rf, rl, sf));
        sent++;
        if (rl) closed_routes++;
    endtask

    task automatic drain_results();
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (pending_legs.size() > 0) @(posedge i_clk);
    endtask

    function automatic logic signed [30:0] rand_lat(bit wild);
        if (wild) return $urandom();
        return $urandom_range(0, 1800000000) - 900000000;
    endfunction

    function automatic logic signed [31:0] rand_lon(bit wild);
        if (wild) return $urandom();
        return longint'($urandom_range(0, 2000000000)) * 9 / 5 - 1800000000;
    endfunction

    // result check and receiver stall
    always @(posedge i_clk) begin
        t_leg_summary e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_legs.size() == 0) begin
                $display("%0t: unexpected result leg=%0d", $time, o_leg_dist);
                errors++;
            end else begin
                e = pending_legs.pop_front();
                checked++;
                if (o_leg_dist !== e.leg) begin
                    $display("%0t: leg_dist exp %0d got %0d", $time, e.leg, o_leg_dist);
                    errors++;
                end
                if (o_route_dist !== e.route) begin
                    $display("%0t: route_dist exp %0d got %0d", $time, e.route, o_route_dist);
                    errors++;
                end
                if (o_route_done !== e.done) begin
                    $display("%0t: route_done exp %0d got %0d", $time, e.done, o_route_done);
                    errors++;
                end
                if (o_best_route !== e.best_idx) begin
                    $display("%0t: best_route exp %0d got %0d", $time, e.best_idx,
                             o_best_route);
                    errors++;
                end
                if (o_best_dist !== e.best_len) begin
                    $display("%0t: best_dist exp %0d got %0d", $time, e.best_len, o_best_dist);
                    errors++;
                end
                if (o_new_best !== e.better) begin
                    $display("%0t: new_best exp %0d got %0d", $time, e.better, o_new_best);
                    errors++;
                end
            end
        end
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1'b1;
        end else if (stall_on) begin
            i_stall <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog on cycles with work pending and no transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (!i_valid && pending_legs.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("haversine_route_length_minimum_top_tb failed");
            $finish;
        end
    end

    task automatic test_directed();
        // missing route start right after reset: leg from latitude 0, longitude 0
        send_waypoint(31'sd10000000, 32'sd20000000, 0, 0, 0);
        // empty set, single-waypoint route
        send_waypoint(31'sd0, 32'sd0, 1, 1, 1);
        // antipodes on the equator
        send_waypoint(31'sd0, 32'sd0, 1, 0, 1);
        send_waypoint(31'sd0, 32'sd1800000000, 0, 1, 0);
        // pole to pole
        send_waypoint(31'sd900000000, -32'sd1800000000, 1, 0, 0);
        send_waypoint(-31'sd900000000, 32'sd1800000000, 0, 1, 0);
        // same point twice, zero-length leg, ties keep the first
        send_waypoint(31'sd123456789, 32'sd987654321, 1, 0, 0);
        send_waypoint(31'sd123456789, 32'sd987654321, 0, 1, 0);
        send_waypoint(31'sd5, 32'sd5, 1, 0, 0);
        send_waypoint(31'sd5, 32'sd5, 0, 1, 0);
        // raw bit-pattern extremes outside the legal range
        send_waypoint(31'h4000_0000, 32'h8000_0000, 1, 0, 1);
        send_waypoint(31'h3FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
        send_waypoint(31'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        send_waypoint(31'h0000_0000, 32'h0000_0000, 0, 1, 0);
        // new set in the middle of a route
        send_waypoint(31'sd450000000, 32'sd900000000, 1, 0, 1);
        send_waypoint(-31'sd450000000, -32'sd900000000, 0, 0, 0);
        send_waypoint(31'sd1, -32'sd1, 0, 0, 1);
        send_waypoint(31'sd2, -32'sd2, 0, 1, 0);
        // short neighbors, last digit moves
        send_waypoint(31'sd0, 32'sd0, 1, 0, 0);
        send_waypoint(31'sd1, 32'sd0, 0, 0, 0);
        send_waypoint(31'sd1, 32'sd1, 0, 1, 0);
        drain_results();
    endtask

    task automatic test_index_saturation();
        // more single-waypoint routes than the index can count
        send_waypoint(31'sd0, 32'sd0, 1, 1, 1);
        for (int i = 0; i < 262; i++)
            send_waypoint(rand_lat(0), rand_lon(0), 1, 1, 0);
        // a real leg after saturation
        send_waypoint(31'sd0, 32'sd0, 1, 0, 0);
        send_waypoint(31'sd0, 32'sd100, 0, 1, 0);
        drain_results();
    endtask

    task automatic test_random_routes(input int count);
        int n, len;
        bit wild;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) < 8) begin
                // well-formed route, new set now and then
                len = $urandom_range(1, 6);
                wild = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < len; k++) begin
                    send_waypoint(rand_lat(wild), rand_lon(wild), k == 0, k == len - 1,
                                  k == 0 && $urandom_range(0, 7) == 0);
                    n++;
                end
            end else begin
                send_waypoint(rand_lat($urandom_range(0, 1)), rand_lon($urandom_range(0, 1)),
                              $urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(0, 5) == 0);
                n++;
            end
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        // receiver holds off while waypoints keep coming, block fills and stalls
        gap_on = 0;
        @(posedge i_clk);
        hold_req = 3000;
        for (int k = 0; k < 6; k++)
            send_waypoint(rand_lat(0), rand_lon(0), k == 0, k == 5, 0);
        drain_results();
        gap_on = 1;
    endtask

    initial begin
        prv_lat = 0;
        prv_lon = 0;
        run_sum = 0;
        run_idx = 0;
        min_sum = 48'hFFFF_FFFF_FFFF;
        min_idx = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        stall_on = 1'b1;
        test_random_routes(300);
        test_backpressure();
        test_index_saturation();
        stall_on = 1'b0;
        test_random_routes(100);
        stall_on = 1'b1;
        test_random_routes(250);
        repeat (300) @(posedge i_clk);
        $display("covered %0d waypoints, %0d results checked, %0d routes closed",
                 sent, checked, closed_routes);
        $display("directed extremes, index saturation, long receiver hold-off, random routes");
        if (errors == 0 && pending_legs.size() == 0) begin
            $display("haversine_route_length_minimum_top_tb passed");
        end else begin
            $display("haversine_route_length_minimum_top_tb failed");
        end
        $finish;
    end

endmodule
